// File: src/tcbs_pkg.sv
// Shared types, widths and constants for the TCB spline point evaluator.
// No dependencies; every other file refers to it by scoped names.
package tcbs_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 12;

  localparam int U_W     = FRAC_BITS + 1;
  localparam int SHAPE_W = FRAC_BITS + 2;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int A_W     = SHAPE_W + 1;
  localparam int AB_W    = 2 * A_W;
  localparam int K_W     = 42;
  localparam int KD_W    = 58;
  localparam int M_W     = 59;
  localparam int H_W     = 40;
  localparam int HC_W    = H_W + 3;
  localparam int HQ_W    = H_W + COORD_BITS;
  localparam int PQ_W    = HQ_W + 1;
  localparam int PP_W    = H_W + M_W;
  localparam int SUM_W   = PP_W + 2;

  localparam int POS_SHIFT = 3 * FRAC_BITS + 1;
  localparam int OUT_SHIFT = 6 * FRAC_BITS + 1;
  localparam int RND_W     = SUM_W - OUT_SHIFT;

  localparam int H_SPLIT = 20;
  localparam int M_SPLIT = 30;

  localparam int NSTAGE = 9;

  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic        [U_W-1:0]       u_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SHAPE_W-1:0]   shape_t;
  typedef logic signed [DIFF_W-1:0]    diff_t;
  typedef logic signed [A_W-1:0]       fac_t;
  typedef logic signed [AB_W-1:0]      ab_t;
  typedef logic signed [K_W-1:0]       coef_t;
  typedef logic signed [KD_W-1:0]      kd_t;
  typedef logic signed [M_W-1:0]       tan_t;
  typedef logic signed [H_W-1:0]       basis_t;
  typedef logic signed [HC_W-1:0]      basis_wide_t;
  typedef logic signed [HQ_W-1:0]      hq_t;
  typedef logic signed [PQ_W-1:0]      pq_t;
  typedef logic signed [PP_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [RND_W-1:0]     rnd_t;

  localparam cfg_idx_t REG_TENSION    = cfg_idx_t'(0);
  localparam cfg_idx_t REG_CONTINUITY = cfg_idx_t'(1);
  localparam cfg_idx_t REG_BIAS       = cfg_idx_t'(2);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    coef_t k0;
    coef_t k1;
    coef_t k2;
    coef_t k3;
  } coef_set_t;

  typedef struct packed {
    basis_t h0;
    basis_t h1;
    basis_t h2;
    basis_t h3;
  } basis_set_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pipe_ctl_t;

endpackage

// File: src/tcbs_if.sv
// Channel interfaces: shape register writes, input items and result items.
// Depends on tcbs_pkg.
interface tcbs_cfg_if;
  logic               valid;
  logic               ready;
  tcbs_pkg::cfg_idx_t index;
  tcbs_pkg::shape_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface tcbs_in_if;
  logic             valid;
  logic             ready;
  tcbs_pkg::u_t     u;
  tcbs_pkg::coord_t p0_x;
  tcbs_pkg::coord_t p0_y;
  tcbs_pkg::coord_t p1_x;
  tcbs_pkg::coord_t p1_y;
  tcbs_pkg::coord_t p2_x;
  tcbs_pkg::coord_t p2_y;
  tcbs_pkg::coord_t p3_x;
  tcbs_pkg::coord_t p3_y;

  modport source (output valid, u, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  input ready);
  modport sink   (input valid, u, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  output ready);
endinterface

interface tcbs_out_if;
  logic             valid;
  logic             ready;
  tcbs_pkg::coord_t out_x;
  tcbs_pkg::coord_t out_y;
  logic             saturated;

  modport source (output valid, out_x, out_y, saturated, input ready);
  modport sink   (input valid, out_x, out_y, saturated, output ready);
endinterface

// File: src/tcbs_coef.sv
// Shape registers and the two-stage tangent weight pipeline k0..k3.
// Depends on tcbs_pkg and tcbs_cfg_if.
module tcbs_coef (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcbs_cfg_if.sink            cfg_i,
  output tcbs_pkg::coef_set_t coef_o
);

  localparam tcbs_pkg::fac_t ONE_F    = tcbs_pkg::fac_t'(1) <<< tcbs_pkg::FRAC_BITS;
  localparam tcbs_pkg::ab_t  AB_RESET = tcbs_pkg::ab_t'(1) <<< (2 * tcbs_pkg::FRAC_BITS);
  localparam tcbs_pkg::coef_t K_RESET = tcbs_pkg::coef_t'(1) <<< (3 * tcbs_pkg::FRAC_BITS);
  localparam int KF_W = tcbs_pkg::AB_W + tcbs_pkg::A_W;

  tcbs_pkg::shape_t    tension_q, continuity_q, bias_q;
  tcbs_pkg::fac_t      one_m_t, one_p_b, one_m_b, one_p_c, one_m_c;
  tcbs_pkg::ab_t       abp_d, abm_d, abp_q, abm_q;
  tcbs_pkg::fac_t      cp_q, cm_q;
  logic signed [KF_W-1:0] k0_full, k1_full, k2_full, k3_full;
  tcbs_pkg::coef_set_t coef_d, coef_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tension_q    <= '0;
      continuity_q <= '0;
      bias_q       <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        tcbs_pkg::REG_TENSION:    tension_q    <= cfg_i.data;
        tcbs_pkg::REG_CONTINUITY: continuity_q <= cfg_i.data;
        tcbs_pkg::REG_BIAS:       bias_q       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    one_m_t = ONE_F - tcbs_pkg::fac_t'(tension_q);
    one_p_b = ONE_F + tcbs_pkg::fac_t'(bias_q);
    one_m_b = ONE_F - tcbs_pkg::fac_t'(bias_q);
    one_p_c = ONE_F + tcbs_pkg::fac_t'(continuity_q);
    one_m_c = ONE_F - tcbs_pkg::fac_t'(continuity_q);
    abp_d   = one_m_t * one_p_b;
    abm_d   = one_m_t * one_m_b;
  end

  always_comb begin
    k0_full   = abp_q * cm_q;
    k1_full   = abm_q * cp_q;
    k2_full   = abp_q * cp_q;
    k3_full   = abm_q * cm_q;
    coef_d.k0 = k0_full[tcbs_pkg::K_W-1:0];
    coef_d.k1 = k1_full[tcbs_pkg::K_W-1:0];
    coef_d.k2 = k2_full[tcbs_pkg::K_W-1:0];
    coef_d.k3 = k3_full[tcbs_pkg::K_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abp_q     <= AB_RESET;
      abm_q     <= AB_RESET;
      cp_q      <= ONE_F;
      cm_q      <= ONE_F;
      coef_q.k0 <= K_RESET;
      coef_q.k1 <= K_RESET;
      coef_q.k2 <= K_RESET;
      coef_q.k3 <= K_RESET;
    end else begin
      abp_q  <= abp_d;
      abm_q  <= abm_d;
      cp_q   <= one_p_c;
      cm_q   <= one_m_c;
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// File: src/tcbs_basis.sv
// Hermite basis pipeline: u, u^2, u^3, then h0..h3, held one more stage.
// Depends on tcbs_pkg.
module tcbs_basis (
  input  logic                 clk_i,
  input  tcbs_pkg::pipe_ctl_t  ctl_i,
  input  tcbs_pkg::u_t         u_i,
  output tcbs_pkg::basis_set_t basis_o
);

  localparam int U2_W = 2 * tcbs_pkg::U_W;
  localparam int U3_W = 3 * tcbs_pkg::U_W;
  localparam tcbs_pkg::basis_wide_t ONE3 =
    tcbs_pkg::basis_wide_t'(1) <<< (3 * tcbs_pkg::FRAC_BITS);

  tcbs_pkg::u_t         u1_q, u2_q;
  logic [U2_W-1:0]      usq_d, usq1_q, usq2_q;
  logic [U3_W-1:0]      ucb_d, ucb_q;
  tcbs_pkg::basis_set_t h_d, h3_q, h4_q;

  assign usq_d = u_i * u_i;
  assign ucb_d = usq1_q * u1_q;

  always_comb begin
    tcbs_pkg::basis_wide_t c3, s2, s1, h0c, h1c, h2c, h3c;
    c3  = tcbs_pkg::basis_wide_t'(ucb_q);
    s2  = tcbs_pkg::basis_wide_t'(usq2_q) <<< tcbs_pkg::FRAC_BITS;
    s1  = tcbs_pkg::basis_wide_t'(u2_q) <<< (2 * tcbs_pkg::FRAC_BITS);
    h0c = (c3 <<< 1) - (s2 + (s2 <<< 1)) + ONE3;
    h1c = (s2 + (s2 <<< 1)) - (c3 <<< 1);
    h2c = c3 - (s2 <<< 1) + s1;
    h3c = c3 - s2;
    h_d.h0 = h0c[tcbs_pkg::H_W-1:0];
    h_d.h1 = h1c[tcbs_pkg::H_W-1:0];
    h_d.h2 = h2c[tcbs_pkg::H_W-1:0];
    h_d.h3 = h3c[tcbs_pkg::H_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      u1_q   <= u_i;
      usq1_q <= usq_d;
    end
    if (ctl_i.en[1]) begin
      u2_q   <= u1_q;
      usq2_q <= usq1_q;
      ucb_q  <= ucb_d;
    end
    if (ctl_i.en[2]) begin
      h3_q <= h_d;
    end
    if (ctl_i.en[3]) begin
      h4_q <= h3_q;
    end
  end

  assign basis_o = h4_q;

endmodule

// File: src/tcbs_lane.sv
// One coordinate axis: tangents, basis products and the rounded-ready sum.
// Depends on tcbs_pkg; fed by tcbs_coef and tcbs_basis.
module tcbs_lane (
  input  logic                 clk_i,
  input  tcbs_pkg::pipe_ctl_t  ctl_i,
  input  tcbs_pkg::coord_t     q0_i,
  input  tcbs_pkg::coord_t     q1_i,
  input  tcbs_pkg::coord_t     q2_i,
  input  tcbs_pkg::coord_t     q3_i,
  input  tcbs_pkg::coef_set_t  coef_i,
  input  tcbs_pkg::basis_set_t basis_i,
  output tcbs_pkg::sum_t       sum_o
);

  localparam int HL_W = tcbs_pkg::H_SPLIT;
  localparam int HH_W = tcbs_pkg::H_W - tcbs_pkg::H_SPLIT;
  localparam int ML_W = tcbs_pkg::M_SPLIT;
  localparam int MH_W = tcbs_pkg::M_W - tcbs_pkg::M_SPLIT;
  localparam tcbs_pkg::sum_t RND = tcbs_pkg::sum_t'(1) <<< (tcbs_pkg::OUT_SHIFT - 1);

  typedef struct packed {
    tcbs_pkg::diff_t  d0;
    tcbs_pkg::diff_t  d1;
    tcbs_pkg::diff_t  d2;
    tcbs_pkg::coord_t q1;
    tcbs_pkg::coord_t q2;
  } lane_pt_t;

  typedef struct packed {
    logic signed [HL_W+ML_W+1:0] ll;
    logic signed [HL_W+MH_W:0]   lh;
    logic signed [HH_W+ML_W:0]   hl;
    logic signed [HH_W+MH_W-1:0] hh;
  } pp_t;

  function automatic pp_t split_mul(tcbs_pkg::basis_t h, tcbs_pkg::tan_t m);
    pp_t r;
    r.ll = $signed({1'b0, h[HL_W-1:0]}) * $signed({1'b0, m[ML_W-1:0]});
    r.lh = $signed({1'b0, h[HL_W-1:0]}) * $signed(m[tcbs_pkg::M_W-1:ML_W]);
    r.hl = $signed(h[tcbs_pkg::H_W-1:HL_W]) * $signed({1'b0, m[ML_W-1:0]});
    r.hh = $signed(h[tcbs_pkg::H_W-1:HL_W]) * $signed(m[tcbs_pkg::M_W-1:ML_W]);
    return r;
  endfunction

  function automatic tcbs_pkg::prod_t join_pp(pp_t p);
    tcbs_pkg::prod_t r;
    r = tcbs_pkg::prod_t'(p.ll)
      + (tcbs_pkg::prod_t'(p.lh) <<< ML_W)
      + (tcbs_pkg::prod_t'(p.hl) <<< HL_W)
      + (tcbs_pkg::prod_t'(p.hh) <<< (HL_W + ML_W));
    return r;
  endfunction

  lane_pt_t pt_d;
  lane_pt_t pt_q [3];

  logic signed [tcbs_pkg::K_W+tcbs_pkg::DIFF_W-1:0] kd0_full, kd1_full, kd2_full, kd3_full;
  tcbs_pkg::kd_t    kd0_q, kd1_q, kd2_q, kd3_q;
  tcbs_pkg::coord_t q1_4q, q2_4q;

  tcbs_pkg::tan_t   m1_d, m2_d, m1_q, m2_q;
  tcbs_pkg::hq_t    hq0_d, hq1_d, hq0_q, hq1_q;
  tcbs_pkg::basis_t h2_q, h3_q;

  pp_t              pa_q, pb_q;
  tcbs_pkg::pq_t    pq_d, pq6_q, pq7_q;

  tcbs_pkg::prod_t  a_q, b_q;
  tcbs_pkg::sum_t   s_d, s_q;

  always_comb begin
    pt_d.d0 = q1_i - q0_i;
    pt_d.d1 = q2_i - q1_i;
    pt_d.d2 = q3_i - q2_i;
    pt_d.q1 = q1_i;
    pt_d.q2 = q2_i;
  end

  always_comb begin
    kd0_full = coef_i.k0 * pt_q[2].d0;
    kd1_full = coef_i.k1 * pt_q[2].d1;
    kd2_full = coef_i.k2 * pt_q[2].d1;
    kd3_full = coef_i.k3 * pt_q[2].d2;
    m1_d     = kd0_q + kd1_q;
    m2_d     = kd2_q + kd3_q;
    hq0_d    = basis_i.h0 * q1_4q;
    hq1_d    = basis_i.h1 * q2_4q;
    pq_d     = hq0_q + hq1_q;
    s_d      = (tcbs_pkg::sum_t'(pq7_q) <<< tcbs_pkg::POS_SHIFT)
             + tcbs_pkg::sum_t'(a_q) + tcbs_pkg::sum_t'(b_q) + RND;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) pt_q[0] <= pt_d;
    if (ctl_i.en[1]) pt_q[1] <= pt_q[0];
    if (ctl_i.en[2]) pt_q[2] <= pt_q[1];
    if (ctl_i.en[3]) begin
      kd0_q <= kd0_full[tcbs_pkg::KD_W-1:0];
      kd1_q <= kd1_full[tcbs_pkg::KD_W-1:0];
      kd2_q <= kd2_full[tcbs_pkg::KD_W-1:0];
      kd3_q <= kd3_full[tcbs_pkg::KD_W-1:0];
      q1_4q <= pt_q[2].q1;
      q2_4q <= pt_q[2].q2;
    end
    if (ctl_i.en[4]) begin
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      hq0_q <= hq0_d;
      hq1_q <= hq1_d;
      h2_q  <= basis_i.h2;
      h3_q  <= basis_i.h3;
    end
    if (ctl_i.en[5]) begin
      pa_q  <= split_mul(h2_q, m1_q);
      pb_q  <= split_mul(h3_q, m2_q);
      pq6_q <= pq_d;
    end
    if (ctl_i.en[6]) begin
      a_q   <= join_pp(pa_q);
      b_q   <= join_pp(pb_q);
      pq7_q <= pq6_q;
    end
    if (ctl_i.en[7]) begin
      s_q <= s_d;
    end
  end

  assign sum_o = s_q;

endmodule

// File: src/tcbs_merge.sv
// Output stage: scale both lane sums, clip each to the coordinate range, merge flags.
// Depends on tcbs_pkg; fed by the two tcbs_lane instances.
module tcbs_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcbs_pkg::pipe_ctl_t ctl_i,
  input  logic                valid_i,
  input  tcbs_pkg::sum_t      sum_x_i,
  input  tcbs_pkg::sum_t      sum_y_i,
  output tcbs_pkg::coord_t    out_x_o,
  output tcbs_pkg::coord_t    out_y_o,
  output logic                sat_o
);

  typedef struct packed {
    tcbs_pkg::coord_t v;
    logic             sat;
  } clip_t;

  function automatic clip_t clip(tcbs_pkg::sum_t s);
    tcbs_pkg::rnd_t r;
    clip_t          c;
    r = $signed(s[tcbs_pkg::SUM_W-1:tcbs_pkg::OUT_SHIFT]);
    if (r > tcbs_pkg::rnd_t'(tcbs_pkg::COORD_MAX)) begin
      c.v   = tcbs_pkg::COORD_MAX;
      c.sat = 1'b1;
    end else if (r < tcbs_pkg::rnd_t'(tcbs_pkg::COORD_MIN)) begin
      c.v   = tcbs_pkg::COORD_MIN;
      c.sat = 1'b1;
    end else begin
      c.v   = r[tcbs_pkg::COORD_BITS-1:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

  clip_t cx, cy;

  assign cx = clip(sum_x_i);
  assign cy = clip(sum_y_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[tcbs_pkg::NSTAGE-1]) begin
      out_x_o <= cx.v;
      out_y_o <= cy.v;
      sat_o   <= cx.sat | cy.sat;
    end
  end

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && sat_o |-> (out_x_o == tcbs_pkg::COORD_MAX || out_x_o == tcbs_pkg::COORD_MIN ||
                          out_y_o == tcbs_pkg::COORD_MAX || out_y_o == tcbs_pkg::COORD_MIN))
    else $error("saturated flag set without a clipped coordinate");

endmodule

// File: src/tcb_spline_point_eval_top.sv
// Top level of the TCB spline point evaluator: x and y lanes side by side.
// Depends on tcbs_pkg, tcbs_if, tcbs_coef, tcbs_basis, tcbs_lane and tcbs_merge.
//
//   port    | role       | transaction
//   --------+------------+---------------------------------------------
//   cfg_i   | sink       | index + data, shape register write
//   in_i    | sink       | u and four control points
//   out_o   | source     | out_x, out_y, saturated
//
// One item per clock sustained while out_o.ready stays high; results pass
// through the nine-stage pipeline, in which the basis-by-tangent
// products run as four partial products over two stages.
// Reset clears the stage valid flags and the shape registers; the tangent
// weights follow a register write through the pipeline registers of tcbs_coef.
// A stalled output holds the last stage; earlier stages keep closing bubbles,
// and in_i.ready falls only when all nine stages hold items.
module tcb_spline_point_eval_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcbs_cfg_if.sink    cfg_i,
  tcbs_in_if.sink     in_i,
  tcbs_out_if.source  out_o
);

  localparam int N = tcbs_pkg::NSTAGE;

  logic [N-1:0]         vld_d, vld_q, rdy;
  tcbs_pkg::pipe_ctl_t  ctl;
  tcbs_pkg::coef_set_t  coef;
  tcbs_pkg::basis_set_t basis;
  tcbs_pkg::sum_t       sum_x, sum_y;
  logic                 in_acc, out_acc;

  always_comb begin
    rdy[N-1] = !vld_q[N-1] || out_o.ready;
    for (int i = N - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_d[0] = rdy[0] ? in_i.valid : vld_q[0];
    for (int i = 1; i < N; i++) begin
      vld_d[i] = rdy[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl.en      = rdy;
  assign in_i.ready  = rdy[0];
  assign out_o.valid = vld_q[N-1];
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;

  tcbs_coef u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  tcbs_basis u_basis (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .u_i     (in_i.u),
    .basis_o (basis)
  );

  tcbs_lane u_lane_x (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .q0_i    (in_i.p0_x),
    .q1_i    (in_i.p1_x),
    .q2_i    (in_i.p2_x),
    .q3_i    (in_i.p3_x),
    .coef_i  (coef),
    .basis_i (basis),
    .sum_o   (sum_x)
  );

  tcbs_lane u_lane_y (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .q0_i    (in_i.p0_y),
    .q1_i    (in_i.p1_y),
    .q2_i    (in_i.p2_y),
    .q3_i    (in_i.p3_y),
    .coef_i  (coef),
    .basis_i (basis),
    .sum_o   (sum_y)
  );

  tcbs_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .valid_i (vld_q[N-1]),
    .sum_x_i (sum_x),
    .sum_y_i (sum_y),
    .out_x_o (out_o.out_x),
    .out_y_o (out_o.out_y),
    .sat_o   (out_o.saturated)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> &vld_q)
    else $error("input stalled while the pipeline has a bubble");

  a_fill_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_acc |=> $countones(vld_q) == $past($countones(vld_q)) + 1)
    else $error("accepted transaction not held in the pipeline");

  a_fill_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc && out_acc |=> $countones(vld_q) + 1 == $past($countones(vld_q)))
    else $error("delivered transaction not removed from the pipeline");

endmodule
